### rtl/rhp_pkg.sv
// ----------------------------------------------------------------------------
// RTP header parser package
// Shared types and constants for the RTP fixed-header parser.
// ----------------------------------------------------------------------------
package rhp_pkg;

  // Size of the RTP fixed header in bytes.
  localparam int unsigned FixedHdrBytes = 12;
  // Byte offset of the extension word count, less four bytes per CSRC word.
  localparam int unsigned ExtLenOffset  = 14;
  // The only RTP version that is accepted.
  localparam logic [1:0]  RtpVersion    = 2'd2;

  // Result status codes.
  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_SHORT    = 3'd1,
    ST_VERSION  = 3'd2,
    ST_TRUNC    = 3'd3,
    ST_OVERSIZE = 3'd4
  } status_e;

  // Header words and trailer byte of one complete packet.
  typedef struct packed {
    logic [31:0] first_word;
    logic [31:0] time_word;
    logic [31:0] source_word;
    logic [15:0] ext_words;
    logic [7:0]  pad_byte;
  } snap_t;

endpackage

### rtl/rhp_capture.sv
// ----------------------------------------------------------------------------
// RTP header parser: byte capture
// Counts packet bytes, captures the fixed header and the extension length,
// and hands a snapshot of each finished packet to the evaluation stage.
// ----------------------------------------------------------------------------
module rhp_capture #(
  parameter int unsigned LENGTH_WIDTH = 16
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic [7:0]              data_byte_i,
  input  logic                    is_last_i,
  input  logic                    snap_ready_i,
  output logic                    snap_valid_o,
  output logic [LENGTH_WIDTH:0]   snap_size_o,
  output rhp_pkg::snap_t          snap_o
);
  import rhp_pkg::*;

  localparam int unsigned CntW = LENGTH_WIDTH + 1;

  logic [CntW-1:0] idx_q, idx_d;
  logic [31:0]     first_q, first_d;
  logic [31:0]     time_q, time_d;
  logic [31:0]     source_q, source_d;
  logic [15:0]     ext_q, ext_d;
  logic [6:0]      ext_pos;
  logic            ext_hit;
  logic            accept;
  logic            snap_load;
  logic            snap_adv;
  logic            snap_v_q;
  logic [CntW-1:0] snap_size_q;
  snap_t           snap_q;

  // A finished packet waits in the snapshot register until the result stage
  // takes it; the input is held only while that register cannot drain.
  assign snap_adv   = snap_v_q && snap_ready_i;
  assign in_stall_o = snap_v_q && !snap_ready_i;
  assign accept     = in_valid_i && !in_stall_o;
  assign snap_load  = accept && is_last_i;

  // Position of the extension length field, two bytes past the end of the CSRC list.
  assign ext_pos = 7'(ExtLenOffset) + {1'b0, first_q[27:24], 2'b00};
  assign ext_hit = first_q[28] &&
                   ((idx_q == CntW'(ext_pos)) || (idx_q == CntW'(ext_pos) + CntW'(1)));

  // Next value of the capture state for the beat on the input.
  always_comb begin
    first_d  = first_q;
    time_d   = time_q;
    source_d = source_q;
    ext_d    = ext_q;
    if (idx_q < CntW'(4)) begin
      first_d = {first_q[23:0], data_byte_i};
    end else if (idx_q < CntW'(8)) begin
      time_d = {time_q[23:0], data_byte_i};
    end else if (idx_q < CntW'(FixedHdrBytes)) begin
      source_d = {source_q[23:0], data_byte_i};
    end else if (ext_hit) begin
      ext_d = {ext_q[7:0], data_byte_i};
    end
    // The count stops once it has passed the largest legal length.
    idx_d = idx_q[CntW-1] ? idx_q : idx_q + CntW'(1);
  end

  // Capture state; it clears after the final beat of each packet.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q    <= '0;
      first_q  <= '0;
      time_q   <= '0;
      source_q <= '0;
      ext_q    <= '0;
    end else if (accept) begin
      if (is_last_i) begin
        idx_q    <= '0;
        first_q  <= '0;
        time_q   <= '0;
        source_q <= '0;
        ext_q    <= '0;
      end else begin
        idx_q    <= idx_d;
        first_q  <= first_d;
        time_q   <= time_d;
        source_q <= source_d;
        ext_q    <= ext_d;
      end
    end
  end

  // Snapshot valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      snap_v_q <= 1'b0;
    end else if (snap_load) begin
      snap_v_q <= 1'b1;
    end else if (snap_adv) begin
      snap_v_q <= 1'b0;
    end
  end

  // Snapshot payload: the final beat is folded in as it is stored.
  always_ff @(posedge clk_i) begin
    if (snap_load) begin
      snap_size_q        <= idx_d;
      snap_q.first_word  <= first_d;
      snap_q.time_word   <= time_d;
      snap_q.source_word <= source_d;
      snap_q.ext_words   <= ext_d;
      snap_q.pad_byte    <= data_byte_i;
    end
  end

  assign snap_valid_o = snap_v_q;
  assign snap_size_o  = snap_size_q;
  assign snap_o       = snap_q;

endmodule

### rtl/rhp_result.sv
// ----------------------------------------------------------------------------
// RTP header parser: result evaluation
// Checks a packet snapshot, works out payload offset and length, and holds
// the result in the output register until the receiver takes it.
// ----------------------------------------------------------------------------
module rhp_result #(
  parameter int unsigned LENGTH_WIDTH = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  snap_valid_i,
  output logic                  snap_ready_o,
  input  logic [LENGTH_WIDTH:0] snap_size_i,
  input  rhp_pkg::snap_t        snap_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [2:0]            status_o,
  output logic                  padding_flag_o,
  output logic                  extension_flag_o,
  output logic [3:0]            csrc_count_o,
  output logic                  marker_o,
  output logic [6:0]            media_type_o,
  output logic [15:0]           sequence_res_o,
  output logic [31:0]           timestamp_o,
  output logic [31:0]           ssrc_o,
  output logic [15:0]           payload_offset_o,
  output logic [15:0]           payload_length_o
);
  import rhp_pkg::*;

  localparam int unsigned CntW  = LENGTH_WIDTH + 1;
  // Wide enough for the header, a full extension and the padding count.
  localparam int unsigned NeedW = ((CntW > 19) ? CntW : 19) + 1;

  logic [NeedW-1:0] size_w;
  logic [NeedW-1:0] hdr_len;
  logic [NeedW-1:0] need_len;
  logic [NeedW-1:0] plen;
  logic [7:0]       pad_cnt;
  logic             pbit, xbit;
  logic [3:0]       ccnt;
  status_e          status;
  logic             adv;
  logic             out_v_q;
  logic [2:0]       status_q;
  logic [31:0]      first_q, time_q, source_q;
  logic [15:0]      offset_q, plen_q;

  assign pbit = snap_i.first_word[29];
  assign xbit = snap_i.first_word[28];
  assign ccnt = snap_i.first_word[27:24];

  // Header length, then everything that must fit before the payload ends.
  assign size_w  = NeedW'(snap_size_i);
  assign pad_cnt = (snap_i.pad_byte == 8'd0) ? 8'd1 : snap_i.pad_byte;
  assign hdr_len = NeedW'(FixedHdrBytes) + (NeedW'(ccnt) << 2) +
                   (xbit ? (NeedW'(4) + (NeedW'(snap_i.ext_words) << 2)) : '0);
  assign need_len = hdr_len + (pbit ? NeedW'(pad_cnt) : '0);
  assign plen     = size_w - need_len;

  // Checks in order of precedence.
  always_comb begin
    priority if (snap_size_i[CntW-1]) begin
      status = ST_OVERSIZE;
    end else if (snap_size_i < CntW'(FixedHdrBytes)) begin
      status = ST_SHORT;
    end else if (snap_i.first_word[31:30] != RtpVersion) begin
      status = ST_VERSION;
    end else if (size_w < need_len) begin
      status = ST_TRUNC;
    end else begin
      status = ST_OK;
    end
  end

  assign adv          = snap_valid_i && snap_ready_o;
  assign snap_ready_o = !out_v_q || !out_stall_i;

  // Output beat valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (adv) begin
      out_v_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_v_q <= 1'b0;
    end
  end

  // Output payload; a short packet reports all header fields as zero.
  always_ff @(posedge clk_i) begin
    if (adv) begin
      status_q <= 3'(status);
      if (status == ST_SHORT) begin
        first_q  <= '0;
        time_q   <= '0;
        source_q <= '0;
      end else begin
        first_q  <= snap_i.first_word;
        time_q   <= snap_i.time_word;
        source_q <= snap_i.source_word;
      end
      if (status == ST_OK) begin
        offset_q <= hdr_len[15:0];
        plen_q   <= plen[15:0];
      end else begin
        offset_q <= '0;
        plen_q   <= '0;
      end
    end
  end

  assign out_valid_o      = out_v_q;
  assign status_o         = status_q;
  assign padding_flag_o   = first_q[29];
  assign extension_flag_o = first_q[28];
  assign csrc_count_o     = first_q[27:24];
  assign marker_o         = first_q[23];
  assign media_type_o     = first_q[22:16];
  assign sequence_res_o   = first_q[15:0];
  assign timestamp_o      = time_q;
  assign ssrc_o           = source_q;
  assign payload_offset_o = offset_q;
  assign payload_length_o = plen_q;

endmodule

### rtl/rtp_header_parser_top.sv
// ----------------------------------------------------------------------------
// RTP header parser, top level
// Parses an RTP packet streamed one byte per beat and reports its header.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel carries one packet byte per beat, with is_last_i high
//   on the final byte. Bytes are taken at one per cycle while in_valid_i is
//   high and in_stall_o is low. The output channel carries one result beat
//   per packet: status, header fields, payload offset and payload length.
//   The final byte passes through the snapshot register and then the output
//   register before out_valid_o rises. A new packet may start in the cycle
//   after a final byte, so back-to-back packets of any length, even one
//   byte, run at full rate while out_stall_i is low.
//   When the receiver stalls, the result holds and one more finished packet
//   waits in the snapshot register; only then does in_stall_o rise.
//   Reset clears the byte count, the captured header and both valid flags.
//   LENGTH_WIDTH sets the longest legal packet, 2^LENGTH_WIDTH - 1 bytes.
// ----------------------------------------------------------------------------
module rtp_header_parser_top #(
  parameter int unsigned LENGTH_WIDTH = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  data_byte_i,
  input  logic        is_last_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  status_o,
  output logic        padding_flag_o,
  output logic        extension_flag_o,
  output logic [3:0]  csrc_count_o,
  output logic        marker_o,
  output logic [6:0]  media_type_o,
  output logic [15:0] sequence_res_o,
  output logic [31:0] timestamp_o,
  output logic [31:0] ssrc_o,
  output logic [15:0] payload_offset_o,
  output logic [15:0] payload_length_o
);
  import rhp_pkg::*;

  logic                  snap_valid;
  logic                  snap_ready;
  logic [LENGTH_WIDTH:0] snap_size;
  snap_t                 snap;

  // Byte capture and packet snapshot.
  rhp_capture #(
    .LENGTH_WIDTH (LENGTH_WIDTH)
  ) u_capture (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .data_byte_i  (data_byte_i),
    .is_last_i    (is_last_i),
    .snap_ready_i (snap_ready),
    .snap_valid_o (snap_valid),
    .snap_size_o  (snap_size),
    .snap_o       (snap)
  );

  // Checks and output register.
  rhp_result #(
    .LENGTH_WIDTH (LENGTH_WIDTH)
  ) u_result (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .snap_valid_i     (snap_valid),
    .snap_ready_o     (snap_ready),
    .snap_size_i      (snap_size),
    .snap_i           (snap),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .status_o         (status_o),
    .padding_flag_o   (padding_flag_o),
    .extension_flag_o (extension_flag_o),
    .csrc_count_o     (csrc_count_o),
    .marker_o         (marker_o),
    .media_type_o     (media_type_o),
    .sequence_res_o   (sequence_res_o),
    .timestamp_o      (timestamp_o),
    .ssrc_o           (ssrc_o),
    .payload_offset_o (payload_offset_o),
    .payload_length_o (payload_length_o)
  );

endmodule
